### hdl/sbplm_pkg.sv
// ----------------------------------------------------------------------------
// sbplm_pkg: shared constants and types for the band peak log meter
// Band edge table, field widths and the records passed between stages.
// ----------------------------------------------------------------------------
package sbplm_pkg;

  localparam int NUM_BANDS = 16;
  localparam int NUM_BINS  = 256;

  localparam int MAG_W     = 32;
  localparam int BIN_W     = $clog2(NUM_BINS);
  localparam int BAND_W    = 4;
  localparam int SHIFT_W   = 4;
  localparam int FRAC_BITS = 5;
  localparam int POS_W     = $clog2(MAG_W);
  localparam int LEVEL_W   = POS_W + FRAC_BITS;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd7;

  // Band b covers bins BAND_EDGE[b] up to, not including, BAND_EDGE[b+1]
  localparam logic [BIN_W:0] BAND_EDGE [0:NUM_BANDS] = '{
    9'd0,   9'd1,   9'd2,   9'd3,   9'd5,   9'd7,   9'd10,  9'd14,  9'd20,
    9'd28,  9'd40,  9'd54,  9'd74,  9'd101, 9'd137, 9'd187, 9'd255
  };

  // Shifted band peak, ready for the log stages
  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic              last_band;
    logic [MAG_W-1:0]  value;
  } peak_t;

  // Peak with its leading-one position found
  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic              last_band;
    logic [MAG_W-1:0]  value;
    logic [POS_W-1:0]  pos;
    logic              zero;
  } lead_t;

endpackage

### hdl/sbplm_if.sv
// ----------------------------------------------------------------------------
// sbplm_if: stream channels of the band peak log meter
// Bin input channel and band level output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sbplm_in_if import sbplm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] magnitude;
  logic             frame_start;

  modport source (output valid, output magnitude, output frame_start, input ready);
  modport sink   (input valid, input magnitude, input frame_start, output ready);
endinterface

interface sbplm_out_if import sbplm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BAND_W-1:0]  band;
  logic [LEVEL_W-1:0] level;
  logic               last_band;

  modport source (output valid, output band, output level, output last_band, input ready);
  modport sink   (input valid, input band, input level, input last_band, output ready);
endinterface

### hdl/sbplm_accum.sv
// ----------------------------------------------------------------------------
// sbplm_accum: bin tracking and band peak accumulation
// Follows bin and band position, keeps the running peak and hands the
// shifted peak of each finished band to the log stages.
// ----------------------------------------------------------------------------
module sbplm_accum import sbplm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [SHIFT_W-1:0] cfg_write_data,
  sbplm_in_if.sink           spectrum,
  output logic               peak_valid,
  output peak_t              peak,
  input  logic               peak_ready
);

  logic [SHIFT_W-1:0] magnitude_shift;
  logic [BIN_W-1:0]   bin_pos;
  logic [BAND_W-1:0]  band_pos;
  logic [MAG_W-1:0]   run_peak;

  logic [BIN_W-1:0]   bin_pos_next;
  logic [BAND_W-1:0]  band_pos_next;
  logic [MAG_W-1:0]   run_peak_next;

  logic [BIN_W-1:0]   cur_bin;
  logic [BAND_W-1:0]  cur_band;
  logic [MAG_W-1:0]   cur_peak;
  logic [MAG_W-1:0]   max_peak;
  logic [BIN_W:0]     edge_lo;
  logic [BIN_W:0]     edge_hi;
  logic [BIN_W:0]     bin_plus;
  logic               in_band;
  logic               band_end;
  logic               band_is_last;
  logic               advance;
  logic               accept;

  assign advance        = !peak_valid || peak_ready;
  assign spectrum.ready = advance;
  assign accept         = spectrum.valid && advance;

  // Restart the frame on a frame start request
  always_comb begin
    cur_bin  = spectrum.frame_start ? '0 : bin_pos;
    cur_band = spectrum.frame_start ? '0 : band_pos;
    cur_peak = spectrum.frame_start ? '0 : run_peak;
  end

  // Band membership and end of band
  always_comb begin
    edge_lo      = BAND_EDGE[{1'b0, cur_band}];
    edge_hi      = BAND_EDGE[{1'b0, cur_band} + (BAND_W+1)'(1)];
    bin_plus     = {1'b0, cur_bin} + (BIN_W+1)'(1);
    in_band      = ({1'b0, cur_bin} >= edge_lo) && ({1'b0, cur_bin} < edge_hi);
    band_end     = in_band && (bin_plus == edge_hi);
    band_is_last = (cur_band == BAND_W'(NUM_BANDS - 1));
    max_peak     = (spectrum.magnitude > cur_peak) ? spectrum.magnitude : cur_peak;
  end

  // Next position and peak
  always_comb begin
    band_pos_next = cur_band;
    run_peak_next = cur_peak;
    if (band_end) begin
      run_peak_next = '0;
      band_pos_next = band_is_last ? '0 : cur_band + BAND_W'(1);
    end else if (in_band) begin
      run_peak_next = max_peak;
    end
    if (cur_bin == BIN_W'(NUM_BINS - 1)) begin
      bin_pos_next  = '0;
      band_pos_next = '0;
      run_peak_next = '0;
    end else begin
      bin_pos_next = cur_bin + BIN_W'(1);
    end
  end

  // Hold the shift setting
  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude_shift <= SHIFT_RESET;
    end else if (cfg_write_en) begin
      magnitude_shift <= cfg_write_data;
    end
  end

  // Advance state on each accepted bin
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_pos  <= '0;
      band_pos <= '0;
      run_peak <= '0;
    end else if (accept) begin
      bin_pos  <= bin_pos_next;
      band_pos <= band_pos_next;
      run_peak <= run_peak_next;
    end
  end

  // Load the finished band peak
  always_ff @(posedge clk) begin
    if (rst) begin
      peak_valid <= 1'b0;
    end else if (advance) begin
      peak_valid <= accept && band_end;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && band_end) begin
      peak.band      <= cur_band;
      peak.last_band <= band_is_last;
      peak.value     <= max_peak >> magnitude_shift;
    end
  end

endmodule

### hdl/sbplm_log.sv
// ----------------------------------------------------------------------------
// sbplm_log: two-stage fixed-point log2 of the band peak
// Finds the leading one, then normalizes and takes the next five bits as
// the fraction.
// ----------------------------------------------------------------------------
module sbplm_log import sbplm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       peak_valid,
  input  peak_t      peak,
  output logic       peak_ready,
  sbplm_out_if.source meter
);

  logic               lead_valid;
  lead_t              lead;
  logic [POS_W-1:0]   pos_find;
  logic               lead_adv;
  logic               out_adv;
  logic [MAG_W-1:0]   norm;
  logic [LEVEL_W-1:0] level_calc;

  assign out_adv    = !meter.valid || meter.ready;
  assign lead_adv   = !lead_valid || out_adv;
  assign peak_ready = lead_adv;

  // Find the leading-one position
  always_comb begin
    pos_find = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (peak.value[i]) begin
        pos_find = POS_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_valid <= 1'b0;
    end else if (lead_adv) begin
      lead_valid <= peak_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lead_adv && peak_valid) begin
      lead.band      <= peak.band;
      lead.last_band <= peak.last_band;
      lead.value     <= peak.value;
      lead.pos       <= pos_find;
      lead.zero      <= (peak.value == '0);
    end
  end

  // Normalize so the leading one sits at the top, take the fraction below it
  always_comb begin
    norm       = lead.value << (POS_W'(MAG_W - 1) - lead.pos);
    level_calc = lead.zero ? '0 : {lead.pos, norm[MAG_W-2 -: FRAC_BITS]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meter.valid <= 1'b0;
    end else if (out_adv) begin
      meter.valid <= lead_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && lead_valid) begin
      meter.band      <= lead.band;
      meter.level     <= level_calc;
      meter.last_band <= lead.last_band;
    end
  end

endmodule

### hdl/spectrum_band_peak_log_meter_top.sv
// ----------------------------------------------------------------------------
// spectrum_band_peak_log_meter_top: 16-band log peak meter
// Groups spectrum bins into log-spaced bands and reports each band's peak
// as a fixed-point log2 level.
// ----------------------------------------------------------------------------
//   channel   dir  payload                          handshake
//   spectrum  in   magnitude[31:0], frame_start      valid/ready
//   meter     out  band[3:0], level[9:0], last_band  valid/ready
//   cfg       in   cfg_write_data[3:0] (shift)       cfg_write_en
//
// One bin is accepted every cycle while spectrum.ready is high; a band's
// level passes the peak, leading-one and normalize registers in turn.
// Reset (rst, synchronous) clears positions and peak; the shift returns to 7.
// A stall on meter backs up through the three registers and then holds
// spectrum.ready low; bins that end no band still need a free first stage.
// ----------------------------------------------------------------------------
module spectrum_band_peak_log_meter_top import sbplm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [SHIFT_W-1:0] cfg_write_data,
  sbplm_in_if.sink           spectrum,
  sbplm_out_if.source        meter
);

  logic  peak_valid;
  logic  peak_ready;
  peak_t peak;

  // Track bins and accumulate band peaks
  sbplm_accum u_accum (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .spectrum       (spectrum),
    .peak_valid     (peak_valid),
    .peak           (peak),
    .peak_ready     (peak_ready)
  );

  // Convert band peaks to log levels
  sbplm_log u_log (
    .clk        (clk),
    .rst        (rst),
    .peak_valid (peak_valid),
    .peak       (peak),
    .peak_ready (peak_ready),
    .meter      (meter)
  );

endmodule
